/* src/bsog_pkg.sv */
// ----------------------------------------------------------------------------
// bsog_pkg: shared types and constants of the broadcast strided offset generator
// Register map, extent lane width and controller/datapath command structs.
// ----------------------------------------------------------------------------
package bsog_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int LANE_W    = 16;
  localparam int IDX_W     = 31;
  localparam int OFS_W     = 32;
  localparam int DIM_W     = 2;   // index of a dimension, 0..MAX_DIMS-1
  localparam int CNT_W     = 3;   // dimension count, 0..7
  localparam int TOTAL_W   = LANE_W * MAX_DIMS;
  localparam int DIV_CNT_W = 5;   // counts quotient bits 0..IDX_W-1

  localparam logic [1:0] REG_DIM_COUNT = 2'd0;
  localparam logic [1:0] REG_SHAPE     = 2'd1;
  localparam logic [1:0] REG_STRIDE_A  = 2'd2;
  localparam logic [1:0] REG_STRIDE_B  = 2'd3;

  typedef struct packed {
    logic            load;       // capture index, clear sums
    logic            prod_step;  // multiply element count by one extent
    logic            div_start;  // begin peeling one digit
    logic            div_step;   // one restoring division bit
    logic            acc_step;   // add coord * stride into sums
    logic [DIM_W-1:0] dim;       // dimension being worked on
    logic            finish;     // latch result into output register
  } bsog_cmd_t;

  typedef struct packed {
    logic            out_of_range;
    logic            div_last;   // last quotient bit this cycle
  } bsog_sts_t;

  function automatic logic [LANE_W-1:0] lane16(input logic [TOTAL_W-1:0] packed_v,
                                               input logic [DIM_W-1:0] d);
    return packed_v[d*LANE_W +: LANE_W];
  endfunction

endpackage

/* src/bsog_datapath.sv */
// ----------------------------------------------------------------------------
// bsog_datapath: digit peeling, element count and offset accumulation
// Bit-serial divider splits the index into coordinates; one 16x16 multiply
// per source per dimension accumulates the offsets.
// ----------------------------------------------------------------------------
module bsog_datapath
  import bsog_pkg::*;
(
  input  logic                clk,
  input  bsog_cmd_t           cmd,
  output bsog_sts_t           sts,
  input  logic [IDX_W-1:0]    linear_index,
  input  logic [TOTAL_W-1:0]  shape_packed,
  input  logic [TOTAL_W-1:0]  stride_a_packed,
  input  logic [TOTAL_W-1:0]  stride_b_packed,
  output logic [OFS_W-1:0]    offset_a,
  output logic [OFS_W-1:0]    offset_b,
  output logic                index_out_of_range
);

  logic [IDX_W-1:0]     rest;
  logic [IDX_W-1:0]     quot;
  logic [LANE_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] bit_cnt;
  logic [IDX_W:0]       total;
  logic [OFS_W-1:0]     sum_a;
  logic [OFS_W-1:0]     sum_b;

  logic [LANE_W-1:0]    ext;
  logic [LANE_W-1:0]    ext_nz;
  logic [IDX_W+LANE_W:0] total_mul;
  logic [LANE_W:0]      rem_sh;
  logic                 rem_ge;
  logic [2*LANE_W-1:0]  prod_a;
  logic [2*LANE_W-1:0]  prod_b;

  assign ext       = lane16(shape_packed, cmd.dim);
  assign ext_nz    = (ext == '0) ? LANE_W'(1) : ext;
  // element count saturates at 2^31: every index is below it from there on
  assign total_mul = total * ext;
  assign rem_sh    = {rem, quot[IDX_W-1]};
  assign rem_ge    = rem_sh >= {1'b0, ext_nz};
  assign prod_a    = rem * lane16(stride_a_packed, cmd.dim);
  assign prod_b    = rem * lane16(stride_b_packed, cmd.dim);

  assign sts.out_of_range = {1'b0, rest} >= total;
  assign sts.div_last     = bit_cnt == DIV_CNT_W'(IDX_W - 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest  <= linear_index;
      total <= (IDX_W+1)'(1);
      sum_a <= '0;
      sum_b <= '0;
    end else begin
      if (cmd.prod_step) begin
        total <= (|total_mul[IDX_W+LANE_W:IDX_W]) ? {1'b1, IDX_W'(0)}
                                                  : total_mul[IDX_W:0];
      end
      if (cmd.div_start) begin
        quot    <= rest;
        rem     <= '0;
        bit_cnt <= '0;
      end
      if (cmd.div_step) begin
        // restoring division: quotient shifts in where the dividend shifts out
        rem     <= rem_ge ? LANE_W'(rem_sh - {1'b0, ext_nz}) : rem_sh[LANE_W-1:0];
        quot    <= {quot[IDX_W-2:0], rem_ge};
        bit_cnt <= bit_cnt + DIV_CNT_W'(1);
      end
      if (cmd.acc_step) begin
        sum_a <= sum_a + OFS_W'(prod_a);
        sum_b <= sum_b + OFS_W'(prod_b);
        rest  <= quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      offset_a           <= sts.out_of_range ? '0 : sum_a;
      offset_b           <= sts.out_of_range ? '0 : sum_b;
      index_out_of_range <= sts.out_of_range;
    end
  end

endmodule

/* src/bsog_ctrl.sv */
// ----------------------------------------------------------------------------
// bsog_ctrl: sequencer for one word
// Counts extents, checks range, then peels digits innermost first.
// ----------------------------------------------------------------------------
module bsog_ctrl
  import bsog_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CNT_W-1:0]  dim_count,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bsog_cmd_t         cmd,
  input  bsog_sts_t         sts
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PROD  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_DIVS  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_ACC   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [DIM_W-1:0] dim;
  logic [DIM_W-1:0] dim_next;
  logic [DIM_W-1:0] last_dim;
  logic             out_full;
  logic             out_full_next;

  always_comb begin
    if (dim_count == '0)                        last_dim = '0;
    else if (dim_count > CNT_W'(MAX_DIMS))      last_dim = DIM_W'(MAX_DIMS - 1);
    else                                        last_dim = DIM_W'(dim_count - 1'b1);
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = out_full;

  always_comb begin
    state_next    = state;
    dim_next      = dim;
    out_full_next = out_full && !out_ready;
    cmd           = '0;
    cmd.dim       = dim;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          dim_next   = '0;
          state_next = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd.prod_step = 1'b1;
        if (dim == last_dim) state_next = ST_CHECK;
        else                 dim_next   = dim + 1'b1;
      end
      ST_CHECK: begin
        if (sts.out_of_range) state_next = ST_DONE;
        else                  state_next = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (dim == '0) state_next = ST_DONE;
        else begin
          dim_next   = dim - 1'b1;
          state_next = ST_DIVS;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_full || out_ready) begin
          cmd.finish    = 1'b1;
          out_full_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      dim      <= '0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      dim      <= dim_next;
      out_full <= out_full_next;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load, cmd.prod_step, cmd.div_start, cmd.div_step, cmd.acc_step,
                cmd.finish}) <= 1)
    else $error("more than one datapath command");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> in_ready && in_valid)
    else $error("load outside accept");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finish did not fill output");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !cmd.finish |=> out_valid)
    else $error("result dropped");

endmodule

/* src/broadcast_strided_offset_generator.sv */
// ----------------------------------------------------------------------------
// broadcast_strided_offset_generator: strided offsets of two broadcast sources
// APB register file, sequencer and bit-serial datapath.
// ----------------------------------------------------------------------------
// Sequence: accept, one extent product per dimension in use and a range check;
//   in range, then per dimension a divide start, 31-bit serial divide and accumulate.
// Throughput: one word at a time; the next word is accepted once the last is in
//   the output register, the bit-serial divider peeling each coordinate in turn.
// Reset: synchronous; registers to dim_count 1, shape 1, strides 0; no word held.
module broadcast_strided_offset_generator
  import bsog_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IDX_W-1:0]   linear_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OFS_W-1:0]   offset_a,
  output logic [OFS_W-1:0]   offset_b,
  output logic               index_out_of_range
);

  logic [CNT_W-1:0]   dim_count;
  logic [TOTAL_W-1:0] shape_packed;
  logic [TOTAL_W-1:0] stride_a_packed;
  logic [TOTAL_W-1:0] stride_b_packed;
  logic               wr_en;
  logic               addr_ok;
  bsog_cmd_t          cmd;
  bsog_sts_t          sts;

  assign pready  = 1'b1;
  assign addr_ok = paddr[2:0] == 3'd0 && paddr[4:3] <= 2'd3;
  assign wr_en   = psel && penable && pwrite && addr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count       <= CNT_W'(1);
      shape_packed    <= TOTAL_W'(1);
      stride_a_packed <= '0;
      stride_b_packed <= '0;
    end else if (wr_en) begin
      case (paddr[4:3])
        REG_DIM_COUNT: dim_count       <= pwdata[CNT_W-1:0];
        REG_SHAPE:     shape_packed    <= pwdata;
        REG_STRIDE_A:  stride_a_packed <= pwdata;
        REG_STRIDE_B:  stride_b_packed <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_DIM_COUNT: prdata = {61'd0, dim_count};
      REG_SHAPE:     prdata = shape_packed;
      REG_STRIDE_A:  prdata = stride_a_packed;
      REG_STRIDE_B:  prdata = stride_b_packed;
      default:       prdata = '0;
    endcase
  end

  bsog_ctrl u_ctrl (
    .clk(clk), .rst(rst), .dim_count(dim_count),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .sts(sts)
  );

  bsog_datapath u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .linear_index(linear_index),
    .shape_packed(shape_packed),
    .stride_a_packed(stride_a_packed),
    .stride_b_packed(stride_b_packed),
    .offset_a(offset_a), .offset_b(offset_b),
    .index_out_of_range(index_out_of_range)
  );

endmodule
